FILE: hw/rtl/cbpf_pkg.sv
// Package for the classic BPF filter engine: widths, function codes,
// instruction field codes and the queue entry type. No dependencies.
package cbpf_pkg;
   localparam int ProgDepth    = 4096;
   localparam int ProgAw       = $clog2(ProgDepth);
   localparam int LenW         = 13;
   localparam int ScratchWords = 16;
   localparam int RecordBytes  = 64;
   localparam int RecWords     = RecordBytes / 4;

   localparam logic [1:0] FUNC_LOAD_SLOT = 2'd0;
   localparam logic [1:0] FUNC_LOAD_WORD = 2'd1;
   localparam logic [1:0] FUNC_RUN       = 2'd2;

   localparam logic [2:0] CLS_LD   = 3'h0;
   localparam logic [2:0] CLS_LDX  = 3'h1;
   localparam logic [2:0] CLS_ST   = 3'h2;
   localparam logic [2:0] CLS_STX  = 3'h3;
   localparam logic [2:0] CLS_ALU  = 3'h4;
   localparam logic [2:0] CLS_JMP  = 3'h5;
   localparam logic [2:0] CLS_RET  = 3'h6;
   localparam logic [2:0] CLS_MISC = 3'h7;

   localparam logic [2:0] MODE_IMM = 3'h0;
   localparam logic [2:0] MODE_ABS = 3'h1;
   localparam logic [2:0] MODE_IND = 3'h2;
   localparam logic [2:0] MODE_MEM = 3'h3;
   localparam logic [2:0] MODE_LEN = 3'h4;
   localparam logic [2:0] MODE_MSH = 3'h5;

   localparam logic [3:0] ALU_ADD = 4'h0;
   localparam logic [3:0] ALU_SUB = 4'h1;
   localparam logic [3:0] ALU_MUL = 4'h2;
   localparam logic [3:0] ALU_DIV = 4'h3;
   localparam logic [3:0] ALU_OR  = 4'h4;
   localparam logic [3:0] ALU_AND = 4'h5;
   localparam logic [3:0] ALU_LSH = 4'h6;
   localparam logic [3:0] ALU_RSH = 4'h7;
   localparam logic [3:0] ALU_NEG = 4'h8;
   localparam logic [3:0] ALU_MOD = 4'h9;
   localparam logic [3:0] ALU_XOR = 4'ha;

   localparam logic [3:0] JMP_JA   = 4'h0;
   localparam logic [3:0] JMP_JEQ  = 4'h1;
   localparam logic [3:0] JMP_JGT  = 4'h2;
   localparam logic [3:0] JMP_JGE  = 4'h3;
   localparam logic [3:0] JMP_JSET = 4'h4;

   localparam logic [1:0] SIZE_W = 2'h0;
   localparam logic [1:0] SIZE_H = 2'h1;
   localparam logic [1:0] SIZE_B = 2'h2;

   localparam logic [4:0] MISC_TAX = 5'h00;
   localparam logic [4:0] MISC_TXA = 5'h10;

   typedef struct packed {
      logic [1:0]  func;
      logic [11:0] entry_index;
      logic [63:0] slot;
      logic [31:0] data_word;
   } cmd_type;
endpackage

FILE: hw/rtl/cbpf_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module cbpf_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hw/rtl/cbpf_front.sv
// Front end: accepts request transfers, drops unused codes and out-of-range
// indexes, and pushes commands into a two-entry queue. Depends on cbpf_pkg.
module cbpf_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_func,
   input  logic [11:0]      req_entry_index,
   input  logic [15:0]      req_op_code,
   input  logic [7:0]       req_jump_true,
   input  logic [7:0]       req_jump_false,
   input  logic [31:0]      req_immediate,
   input  logic [31:0]      req_data_word,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output cbpf_pkg::cmd_type cmd_data
);
   import cbpf_pkg::*;

   cmd_type    q_ff [2];
   cmd_type    new_cmd;
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic       keep, push, pop;

   assign req_ready = (cnt_ff != 2'd2);
   assign new_cmd.func = req_func;
   assign new_cmd.entry_index = req_entry_index;
   assign new_cmd.slot = {req_immediate, req_jump_false, req_jump_true, req_op_code};
   assign new_cmd.data_word = req_data_word;

   always_comb begin
      case (req_func)
         FUNC_LOAD_SLOT: keep = 1'b1;
         FUNC_LOAD_WORD: keep = (req_entry_index < 12'(RecWords));
         FUNC_RUN:       keep = 1'b1;
         default:        keep = 1'b0;
      endcase
   end

   assign push = req_valid && req_ready && keep;
   assign pop = cmd_valid && cmd_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data = q_ff[rd_ptr_ff];
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   assign rd_ptr_in = rd_ptr_ff ^ pop;
   assign wr_ptr_in = wr_ptr_ff ^ push;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2) else $error("queue count out of range");
   a_push_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !push) else $error("push into full queue");
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> !pop) else $error("pop from empty queue");
endmodule

FILE: hw/rtl/cbpf_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle, giving quotient
// and remainder. Depends on nothing.
module cbpf_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);
   logic [31:0] q_ff, q_in, r_ff, r_in, d_ff;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff;
   logic [32:0] trial;

   assign trial = {r_ff, q_ff[31]} - {1'b0, d_ff};

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         q_in = dividend;
         r_in = '0;
         cnt_in = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            r_in = trial[31:0];
            q_in = {q_ff[30:0], 1'b1};
         end else begin
            r_in = {r_ff[30:0], q_ff[31]};
            q_in = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         busy_in = (cnt_ff != 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= busy_ff && (cnt_ff == 6'd1);
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      if (start) begin
         d_ff <= divisor;
      end
   end

   assign done = done_ff;
   assign quotient = q_ff;
   assign remainder = r_ff;
endmodule

FILE: hw/rtl/cbpf_back.sv
// Back end: applies queued commands, holds program RAM, record and scratch
// words, and runs the filter. Depends on cbpf_pkg, cbpf_ram, cbpf_divider.
module cbpf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [12:0]       program_length,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  cbpf_pkg::cmd_type cmd_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [31:0]       rsp_verdict,
   output logic              rsp_faulted
);
   import cbpf_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FETCH = 3'd1;
   localparam logic [2:0] ST_EXEC  = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [31:0] rec_ff [RecWords];
   logic [31:0] scr_ff [ScratchWords];
   logic [ScratchWords-1:0] scr_vld_ff;
   logic [31:0] a_ff, a_in, x_ff, x_in;
   logic [12:0] pc_ff, pc_in, len_ff;
   logic [31:0] verdict_ff, verdict_in;
   logic        faulted_ff, faulted_in, out_vld_ff;
   logic        is_mod_ff, is_mod_in;
   logic        take_cmd, prog_wr, run_start;
   logic [ProgAw-1:0] prog_rd_addr;
   logic [63:0] ins;
   logic [15:0] code;
   logic [7:0]  jt, jf;
   logic [31:0] k, src;
   logic [2:0]  mode;
   logic [3:0]  op;
   logic [1:0]  size;
   logic [12:0] room;
   logic        scr_we;
   logic [3:0]  scr_wa;
   logic [31:0] scr_wd;
   logic [31:0] scr_k;
   logic [31:0] lw, lword, lhalf, lbyte;
   logic [32:0] off;
   logic [5:0]  off_hi;
   logic [63:0] lpair;
   logic [6:0]  endb;
   logic [31:0] skip;
   logic        cond, div_start, div_done;
   logic [31:0] div_q, div_r;
   logic [63:0] prod;

   assign take_cmd = cmd_valid && (state_ff == ST_IDLE) && !out_vld_ff;
   assign cmd_ready = take_cmd;
   assign prog_wr = take_cmd && (cmd_data.func == FUNC_LOAD_SLOT);
   assign run_start = take_cmd && (cmd_data.func == FUNC_RUN);
   assign prog_rd_addr = ProgAw'(pc_in);

   cbpf_ram #(.Width(64), .Depth(ProgDepth)) u_prog (
      .clock  (clock),
      .wr_en  (prog_wr),
      .wr_addr(cmd_data.entry_index[ProgAw-1:0]),
      .wr_data(cmd_data.slot),
      .rd_addr(prog_rd_addr),
      .rd_data(ins)
   );

   assign code = ins[15:0];
   assign jt = ins[23:16];
   assign jf = ins[31:24];
   assign k = ins[63:32];
   assign mode = code[7:5];
   assign op = code[7:4];
   assign size = code[4:3];
   assign src = code[3] ? x_ff : k;
   assign room = len_ff - pc_ff - 13'd1;
   assign scr_k = scr_vld_ff[k[3:0]] ? scr_ff[k[3:0]] : '0;
   assign prod = a_ff * src;
   assign off = (mode == MODE_IND) ? ({1'b0, x_ff} + {1'b0, k}) : {1'b0, k};
   assign off_hi = off[5:0] + 6'd3;
   assign lpair = {rec_ff[off_hi[5:2]], rec_ff[off[5:2]]} >> {off[1:0], 3'b000};
   assign lw = (off[32:6] == '0) ? lpair[31:0] : '0;
   assign lword = lw;
   assign lhalf = {16'd0, lw[15:0]};
   assign lbyte = {24'd0, lw[7:0]};

   always_comb begin
      case (size)
         SIZE_H:  endb = 7'd2;
         SIZE_B:  endb = 7'd1;
         default: endb = 7'd4;
      endcase
   end

   always_comb begin
      case (op)
         JMP_JEQ:  cond = (a_ff == src);
         JMP_JGT:  cond = (a_ff > src);
         JMP_JGE:  cond = (a_ff >= src);
         default:  cond = ((a_ff & src) != 0);
      endcase
   end

   always_comb begin
      state_in = state_ff;
      a_in = a_ff;
      x_in = x_ff;
      pc_in = pc_ff;
      verdict_in = verdict_ff;
      faulted_in = faulted_ff;
      is_mod_in = is_mod_ff;
      scr_we = 1'b0;
      scr_wa = k[3:0];
      scr_wd = a_ff;
      div_start = 1'b0;
      skip = '0;
      case (state_ff)
         ST_IDLE: begin
            if (run_start) begin
               a_in = '0;
               x_in = '0;
               pc_in = '0;
               if (program_length == 13'd0 || program_length > 13'(ProgDepth)) begin
                  verdict_in = '0;
                  faulted_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: state_in = ST_EXEC;
         ST_EXEC: begin
            verdict_in = '0;
            faulted_in = 1'b1;
            state_in = ST_DONE;
            case (code[2:0])
               CLS_LD: begin
                  if (mode == MODE_IMM) begin
                     a_in = k; state_in = ST_FETCH;
                  end else if (mode == MODE_LEN) begin
                     a_in = 32'(RecordBytes); state_in = ST_FETCH;
                  end else if (mode == MODE_ABS || mode == MODE_IND) begin
                     if (({1'b0, off} + 34'(endb)) <= 34'(RecordBytes)) begin
                        a_in = (size == SIZE_H) ? lhalf : (size == SIZE_B) ? lbyte : lword;
                        state_in = ST_FETCH;
                     end
                  end else if (mode == MODE_MEM) begin
                     if (k < 32'(ScratchWords)) begin
                        a_in = scr_k; state_in = ST_FETCH;
                     end
                  end
               end
               CLS_LDX: begin
                  if (mode == MODE_IMM) begin
                     x_in = k; state_in = ST_FETCH;
                  end else if (mode == MODE_LEN) begin
                     x_in = 32'(RecordBytes); state_in = ST_FETCH;
                  end else if (mode == MODE_MEM) begin
                     if (k < 32'(ScratchWords)) begin
                        x_in = scr_k; state_in = ST_FETCH;
                     end
                  end else if (mode == MODE_MSH) begin
                     if (k < 32'(RecordBytes)) begin
                        x_in = {26'd0, lbyte[3:0], 2'b00}; state_in = ST_FETCH;
                     end
                  end
               end
               CLS_ST, CLS_STX: begin
                  if (k < 32'(ScratchWords)) begin
                     scr_we = 1'b1;
                     scr_wd = code[0] ? x_ff : a_ff;
                     state_in = ST_FETCH;
                  end
               end
               CLS_ALU: begin
                  state_in = ST_FETCH;
                  case (op)
                     ALU_ADD: a_in = a_ff + src;
                     ALU_SUB: a_in = a_ff - src;
                     ALU_MUL: a_in = prod[31:0];
                     ALU_OR:  a_in = a_ff | src;
                     ALU_AND: a_in = a_ff & src;
                     ALU_LSH: a_in = (src < 32'd32) ? (a_ff << src[4:0]) : '0;
                     ALU_RSH: a_in = (src < 32'd32) ? (a_ff >> src[4:0]) : '0;
                     ALU_NEG: a_in = 32'd0 - a_ff;
                     ALU_XOR: a_in = a_ff ^ src;
                     ALU_DIV, ALU_MOD: begin
                        if (src == '0) begin
                           state_in = ST_DONE;
                        end else begin
                           div_start = 1'b1;
                           is_mod_in = (op == ALU_MOD);
                           state_in = ST_DIV;
                        end
                     end
                     default: state_in = ST_DONE;
                  endcase
               end
               CLS_JMP: begin
                  if (op == JMP_JA) begin
                     skip = k;
                  end else begin
                     skip = {24'd0, cond ? jt : jf};
                  end
                  if ((op == JMP_JA || op == JMP_JEQ || op == JMP_JGT || op == JMP_JGE ||
                       op == JMP_JSET) && skip < {19'd0, room}) begin
                     state_in = ST_FETCH;
                     pc_in = pc_ff + skip[12:0];
                  end
               end
               CLS_RET: begin
                  verdict_in = (size == SIZE_B) ? a_ff : k;
                  faulted_in = 1'b0;
               end
               default: begin
                  if (code[7:3] == MISC_TAX) begin
                     x_in = a_ff; state_in = ST_FETCH;
                  end else if (code[7:3] == MISC_TXA) begin
                     a_in = x_ff; state_in = ST_FETCH;
                  end
               end
            endcase
            if (state_in == ST_FETCH) begin
               pc_in = pc_in + 13'd1;
               if (pc_in >= len_ff) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               a_in = is_mod_ff ? div_r : div_q;
               pc_in = pc_ff + 13'd1;
               state_in = (pc_in >= len_ff) ? ST_DONE : ST_FETCH;
               verdict_in = '0;
               faulted_in = 1'b1;
            end
         end
         ST_DONE: begin
            if (!out_vld_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   cbpf_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (a_ff),
      .divisor  (src),
      .done     (div_done),
      .quotient (div_q),
      .remainder(div_r)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_vld_ff <= 1'b0;
         scr_vld_ff <= '0;
         for (int i = 0; i < RecWords; i++) begin
            rec_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DONE && !out_vld_ff) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
         if (take_cmd && cmd_data.func == FUNC_LOAD_WORD) begin
            rec_ff[cmd_data.entry_index[3:0]] <= cmd_data.data_word;
         end
         if (run_start) begin
            scr_vld_ff <= '0;
         end else if (scr_we) begin
            scr_vld_ff[scr_wa] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      x_ff <= x_in;
      pc_ff <= pc_in;
      verdict_ff <= verdict_in;
      faulted_ff <= faulted_in;
      is_mod_ff <= is_mod_in;
      if (run_start) begin
         len_ff <= program_length;
      end
      if (scr_we) begin
         scr_ff[scr_wa] <= scr_wd;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_verdict = verdict_ff;
   assign rsp_faulted = faulted_ff;

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_faulted |-> rsp_verdict == '0) else $error("fault with nonzero verdict");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !cmd_ready) else $error("command taken while running");
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV) else $error("divider done outside divide");
endmodule

FILE: hw/rtl/classic_bpf_filter_engine.sv
// Classic BPF filter engine: a front queue feeding an execution back end that
// runs a filter over a 64-byte record. Depends on cbpf_pkg, cbpf_front, cbpf_back.
//
// Program slot and record word loads each write one entry when the back end
// takes them. A run handles each instruction as a program RAM read, then
// execute; each DIV or MOD also waits for the 32-step divider. Runs go one at a
// time; the request side keeps accepting into a two-entry queue meanwhile.
module classic_bpf_filter_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [12:0] csr_program_length,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [11:0] req_entry_index,
   input  logic [15:0] req_op_code,
   input  logic [7:0]  req_jump_true,
   input  logic [7:0]  req_jump_false,
   input  logic [31:0] req_immediate,
   input  logic [31:0] req_data_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_verdict,
   output logic        rsp_faulted
);
   import cbpf_pkg::*;

   logic [12:0] len_ff;
   logic        cmd_valid, cmd_ready;
   cmd_type     cmd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (csr_valid) begin
         len_ff <= csr_program_length;
      end
   end

   cbpf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_entry_index(req_entry_index),
      .req_op_code    (req_op_code),
      .req_jump_true  (req_jump_true),
      .req_jump_false (req_jump_false),
      .req_immediate  (req_immediate),
      .req_data_word  (req_data_word),
      .cmd_valid      (cmd_valid),
      .cmd_ready      (cmd_ready),
      .cmd_data       (cmd_data)
   );

   cbpf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .program_length(len_ff),
      .cmd_valid     (cmd_valid),
      .cmd_ready     (cmd_ready),
      .cmd_data      (cmd_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_verdict   (rsp_verdict),
      .rsp_faulted   (rsp_faulted)
   );
endmodule
